// ===== hdl/rclfr_pkg.sv =====
`default_nettype none
package rclfr_pkg;

	localparam int BUF_BYTES     = 64;
	localparam int BUF_AW        = 6;
	localparam int MAX_FRAME_LEN = 62;
	localparam int MIN_FRAME_LEN = 3;
	localparam int NUM_CHANNELS  = 16;
	localparam int MAX_RESULTS   = 64;
	localparam int CHAN_BITS     = 11;
	localparam int PROD_W        = 21;

	localparam logic [7:0]  CRC_POLY      = 8'hD5;
	localparam logic [7:0]  TYPE_CHANNELS = 8'h16;
	localparam logic [11:0] SCALE_BASE    = 12'd1000;

	localparam logic [2:0] REG_FC_ADDRESS  = 3'd0;
	localparam logic [2:0] REG_RAW_LOW     = 3'd1;
	localparam logic [2:0] REG_RAW_HIGH    = 3'd2;
	localparam logic [2:0] REG_PKT_TIMEOUT = 3'd3;
	localparam logic [2:0] REG_FAILSAFE    = 3'd4;
	localparam logic [2:0] REG_PASSTHROUGH = 3'd5;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [11:0] value;
		logic [7:0]  frame_type;
		logic [3:0]  channel_index;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  fc_address;
		logic [10:0] raw_low;
		logic [10:0] raw_high;
		logic [15:0] packet_timeout_ms;
		logic [15:0] failsafe_ms;
		logic        passthrough;
	} cfg_t;

	typedef enum logic [2:0] {
		KIND_ECHO  = 3'd0,
		KIND_CHAN  = 3'd1,
		KIND_UP    = 3'd2,
		KIND_DOWN  = 3'd3,
		KIND_OTHER = 3'd4
	} kind_t;

	typedef enum logic [1:0] {OFF_ZERO, OFF_ONE, OFF_TWO, OFF_IDX} rd_off_t;
	typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_TWO, IDX_INC, IDX_CHAN} idx_op_t;
	typedef enum logic [2:0] {DROP_NONE, DROP_ONE, DROP_FRAME, DROP_ALL, DROP_FULL} drop_op_t;
	typedef enum logic [1:0] {VAL_ZERO, VAL_BYTE, VAL_RDATA, VAL_SCALE} val_sel_t;

	typedef struct packed {
		logic     latch;
		logic     byte_start;
		logic     tick_upd;
		logic     append;
		logic     rd;
		rd_off_t  rd_off;
		idx_op_t  idx_op;
		logic     len_ld;
		logic     crc_clr;
		logic     crc_step;
		logic     addr_ld;
		logic     type_ld;
		logic     win_clr;
		logic     win_shift;
		logic     ch_clr;
		logic     ch_inc;
		logic     mul_ld;
		logic     div_start;
		drop_op_t drop_op;
		logic     link_set;
		logic     link_clr;
		logic     emit;
		kind_t    kind;
		val_sel_t val_sel;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic passthru;
		logic fill_le1;
		logic len_bad;
		logic enough;
		logic crc_last;
		logic crc_ok;
		logic chan_hit;
		logic link;
		logic flush;
		logic down;
		logic flush_more;
		logic last_chan;
		logic div_busy;
		logic out_free;
	} dp_stat_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/rclfr_div.sv =====
`default_nettype none
module rclfr_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rclfr_pkg::PROD_W-1:0]   dividend,
	input  wire logic [rclfr_pkg::CHAN_BITS-1:0] divisor,
	output logic                               busy,
	output logic [rclfr_pkg::PROD_W-1:0]        quotient
);
	import rclfr_pkg::*;

	logic [CHAN_BITS:0]   rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [CHAN_BITS-1:0] dsr_q;
	logic [4:0]           cnt_q;
	logic                 busy_q;
	logic [CHAN_BITS+1:0] trial;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[PROD_W-1]} - {2'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(PROD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == 5'd0) busy_q <= 1'b0;
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[CHAN_BITS+1]) begin
				rem_q <= trial[CHAN_BITS:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CHAN_BITS-1:0], quo_q[PROD_W-1]};
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== hdl/rclfr_dp.sv =====
`default_nettype none
module rclfr_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rclfr_pkg::dp_cmd_t   cmd,
	output rclfr_pkg::dp_stat_t       stat,
	input  wire rclfr_pkg::cfg_t      cfg,
	input  wire rclfr_pkg::in_item_t  in_item,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output rclfr_pkg::out_item_t      out_item
);
	import rclfr_pkg::*;

	logic [7:0]        mem [BUF_BYTES];
	logic [BUF_AW-1:0] head_q;
	logic [BUF_AW:0]   fill_q;
	logic [15:0]       idle_q, since_q;
	logic              link_q;
	in_item_t          item_q;
	logic [7:0]        rdata_q;
	logic              rok_q;
	logic [7:0]        len_q, crc_q, type_q;
	logic              addr_hit_q;
	logic [BUF_AW:0]   idx_q;
	logic [23:0]       win_q;
	logic [3:0]        ch_q;
	logic [PROD_W-1:0] mag_s1;
	logic              neg_s1;
	out_item_t         pend_q, out_q;
	logic              pend_v_q, out_v_q;
	logic [6:0]        res_n_q;

	logic [BUF_AW-1:0] rd_addr, wr_addr, rd_off;
	logic [8:0]        len_p1, len_p2;
	logic [7:0]        ch_bits;
	logic [23:0]       win_sh;
	logic [10:0]       raw;
	logic signed [11:0] diff_s, den_s;
	logic signed [21:0] prod;
	logic [10:0]       den_mag;
	logic              den_zero;
	logic              div_busy;
	logic [PROD_W-1:0] quo;
	logic [22:0]       sv;
	logic [11:0]       scaled, new_val;
	logic [BUF_AW:0]   room;
	logic              down;
	out_item_t         new_item;
	logic              take, send_pend;

	assign len_p1  = {1'b0, len_q} + 9'd1;
	assign len_p2  = {1'b0, len_q} + 9'd2;
	assign ch_bits = 8'({4'b0, ch_q} * 8'(CHAN_BITS));

	always_comb begin
		unique case (cmd.rd_off)
			OFF_ZERO: rd_off = '0;
			OFF_ONE:  rd_off = BUF_AW'(1);
			OFF_TWO:  rd_off = BUF_AW'(2);
			OFF_IDX:  rd_off = idx_q[BUF_AW-1:0];
			default:  rd_off = '0;
		endcase
	end
	assign rd_addr = head_q + rd_off;
	assign wr_addr = head_q + fill_q[BUF_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.append && !fill_q[BUF_AW]) mem[wr_addr] <= item_q.rx_byte;
		if (cmd.rd) begin
			rdata_q <= mem[rd_addr];
			rok_q   <= {2'b0, idx_q} < len_p1;
		end
	end

	// channel unpack and scaling
	assign win_sh   = win_q >> ch_bits[2:0];
	assign raw      = win_sh[10:0];
	assign diff_s   = $signed({1'b0, raw}) - $signed({1'b0, cfg.raw_low});
	assign den_s    = $signed({1'b0, cfg.raw_high}) - $signed({1'b0, cfg.raw_low});
	assign den_mag  = den_s[11] ? 11'(-den_s) : den_s[10:0];
	assign den_zero = den_s == 12'sd0;
	assign prod     = 22'(diff_s) * 22'sd1000;

	rclfr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag_s1),
		.divisor  (den_mag),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign sv = neg_s1 ? (23'(SCALE_BASE) - {2'b0, quo}) : (23'(SCALE_BASE) + {2'b0, quo});
	always_comb begin
		if (den_zero)             scaled = SCALE_BASE;
		else if (sv[22])          scaled = '0;
		else if (sv[21:12] != '0) scaled = 12'hFFF;
		else                      scaled = sv[11:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch)    item_q <= in_item;
		if (cmd.len_ld)   len_q <= rdata_q;
		if (cmd.crc_clr)  crc_q <= '0;
		else if (cmd.crc_step) crc_q <= crc8_step(crc_q, rdata_q);
		if (cmd.addr_ld)  addr_hit_q <= rdata_q == cfg.fc_address;
		if (cmd.type_ld)  type_q <= rdata_q;
		if (cmd.win_clr)  win_q <= '0;
		else if (cmd.win_shift) win_q <= {rok_q ? rdata_q : 8'h00, win_q[23:8]};
		if (cmd.ch_clr)   ch_q <= '0;
		else if (cmd.ch_inc) ch_q <= ch_q + 4'd1;
		if (cmd.mul_ld) begin
			mag_s1 <= prod[21] ? PROD_W'(-prod) : prod[PROD_W-1:0];
			neg_s1 <= prod[21] ^ den_s[11];
		end
		unique case (cmd.idx_op)
			IDX_HOLD: ;
			IDX_ZERO: idx_q <= '0;
			IDX_TWO:  idx_q <= (BUF_AW+1)'(2);
			IDX_INC:  idx_q <= idx_q + 1'b1;
			IDX_CHAN: idx_q <= (BUF_AW+1)'(MIN_FRAME_LEN) + (BUF_AW+1)'(ch_bits[7:3]);
			default:  ;
		endcase
	end

	// result staging: hold one result back so the final one can carry last
	always_comb begin
		unique case (cmd.val_sel)
			VAL_ZERO:  new_val = '0;
			VAL_BYTE:  new_val = {4'b0, item_q.rx_byte};
			VAL_RDATA: new_val = {4'b0, rdata_q};
			VAL_SCALE: new_val = scaled;
			default:   new_val = '0;
		endcase
		new_item.kind          = cmd.kind;
		new_item.value         = new_val;
		new_item.frame_type    = (cmd.kind == KIND_CHAN || cmd.kind == KIND_OTHER) ? type_q : '0;
		new_item.channel_index = (cmd.kind == KIND_CHAN) ? ch_q : '0;
		new_item.last          = 1'b0;
	end
	assign take      = cmd.emit && (res_n_q < 7'(MAX_RESULTS));
	assign send_pend = pend_v_q && (take || cmd.finish);

	always_ff @(posedge clk) begin
		if (take) pend_q <= new_item;
		if (send_pend) begin
			out_q      <= pend_q;
			out_q.last <= cmd.finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			fill_q   <= '0;
			idle_q   <= '0;
			since_q  <= '0;
			link_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			res_n_q  <= '0;
		end else begin
			if (cmd.byte_start) idle_q <= '0;
			if (cmd.tick_upd) begin
				if (idle_q != 16'hFFFF)  idle_q  <= idle_q + 16'd1;
				if (since_q != 16'hFFFF) since_q <= since_q + 16'd1;
			end
			if (cmd.link_set) begin
				link_q  <= 1'b1;
				since_q <= '0;
			end else if (cmd.link_clr) begin
				link_q <= 1'b0;
			end
			if (cmd.append && !fill_q[BUF_AW]) fill_q <= fill_q + 1'b1;
			unique case (cmd.drop_op)
				DROP_NONE: ;
				DROP_ONE: begin
					head_q <= head_q + 1'b1;
					fill_q <= fill_q - 1'b1;
				end
				DROP_FRAME: begin
					if (len_p2 >= {2'b0, fill_q}) begin
						fill_q <= '0;
					end else begin
						head_q <= head_q + len_p2[BUF_AW-1:0];
						fill_q <= fill_q - len_p2[BUF_AW:0];
					end
				end
				DROP_ALL:  fill_q <= '0;
				DROP_FULL: if (fill_q[BUF_AW]) fill_q <= '0;
				default:   ;
			endcase
			if (cmd.finish) begin
				pend_v_q <= 1'b0;
				res_n_q  <= '0;
			end else if (take) begin
				pend_v_q <= 1'b1;
				res_n_q  <= res_n_q + 7'd1;
			end
			if (send_pend)      out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	assign down = link_q && (since_q > cfg.failsafe_ms);
	assign room = down ? (BUF_AW+1)'(MAX_RESULTS - 1) : (BUF_AW+1)'(MAX_RESULTS);

	always_comb begin
		stat.is_tick    = item_q.cmd;
		stat.passthru   = cfg.passthrough;
		stat.fill_le1   = fill_q <= (BUF_AW+1)'(1);
		stat.len_bad    = len_q < 8'(MIN_FRAME_LEN) || len_q > 8'(MAX_FRAME_LEN);
		stat.enough     = {2'b0, fill_q} >= len_p2;
		stat.crc_last   = {2'b0, idx_q} == len_p1;
		stat.crc_ok     = crc_q == rdata_q;
		stat.chan_hit   = addr_hit_q && (type_q == TYPE_CHANNELS);
		stat.link       = link_q;
		stat.flush      = (fill_q != '0) && (idle_q > cfg.packet_timeout_ms);
		stat.down       = down;
		stat.flush_more = ((idx_q + 1'b1) < fill_q) && (idx_q < room);
		stat.last_chan  = ch_q == 4'(NUM_CHANNELS - 1);
		stat.div_busy   = div_busy;
		stat.out_free   = !out_v_q || out_ready;
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;
endmodule
`default_nettype wire

// ===== hdl/rclfr_ctrl.sv =====
`default_nettype none
module rclfr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire rclfr_pkg::dp_stat_t stat,
	output rclfr_pkg::dp_cmd_t       cmd
);
	import rclfr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_PASS, ST_SCAN, ST_LEN, ST_LCHK, ST_ECHO_DROP,
		ST_CRC_RD, ST_CRC_ACC, ST_CRC_CMP, ST_F_ADDR, ST_F_TYPE, ST_F_DEC,
		ST_F_OTHER, ST_F_UP, ST_CH_W0, ST_CH_R0, ST_CH_R1, ST_CH_R2, ST_CH_R3,
		ST_CH_MUL, ST_CH_DIV, ST_CH_WAIT, ST_CH_EMIT, ST_CH_DONE, ST_F_DROP,
		ST_FULLCHK, ST_FINISH, ST_T_CHK, ST_T_FL, ST_T_FE, ST_T_DOWN
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (stat.is_tick) begin
					cmd.tick_upd = 1'b1;
					state_d      = ST_T_CHK;
				end else begin
					cmd.byte_start = 1'b1;
					if (stat.passthru) begin
						state_d = ST_PASS;
					end else begin
						cmd.append = 1'b1;
						state_d    = ST_SCAN;
					end
				end
			end
			ST_PASS: if (stat.out_free) begin
				cmd.emit    = 1'b1;
				cmd.kind    = KIND_ECHO;
				cmd.val_sel = VAL_BYTE;
				state_d     = ST_FINISH;
			end
			ST_SCAN: begin
				if (stat.fill_le1) begin
					state_d = ST_FULLCHK;
				end else begin
					cmd.rd     = 1'b1;
					cmd.rd_off = OFF_ONE;
					state_d    = ST_LEN;
				end
			end
			ST_LEN: begin
				cmd.len_ld = 1'b1;
				state_d    = ST_LCHK;
			end
			ST_LCHK: begin
				priority if (stat.len_bad) begin
					cmd.rd     = 1'b1;
					cmd.rd_off = OFF_ZERO;
					state_d    = ST_ECHO_DROP;
				end else if (stat.enough) begin
					cmd.crc_clr = 1'b1;
					cmd.idx_op  = IDX_TWO;
					state_d     = ST_CRC_RD;
				end else begin
					state_d = ST_FULLCHK;
				end
			end
			ST_ECHO_DROP: if (stat.out_free) begin
				cmd.emit    = 1'b1;
				cmd.kind    = KIND_ECHO;
				cmd.val_sel = VAL_RDATA;
				cmd.drop_op = DROP_ONE;
				state_d     = ST_SCAN;
			end
			ST_CRC_RD: begin
				cmd.rd     = 1'b1;
				cmd.rd_off = OFF_IDX;
				cmd.idx_op = IDX_INC;
				state_d    = ST_CRC_ACC;
			end
			ST_CRC_ACC: begin
				cmd.crc_step = 1'b1;
				cmd.rd       = 1'b1;
				cmd.rd_off   = OFF_IDX;
				if (stat.crc_last) state_d = ST_CRC_CMP;
				else               cmd.idx_op = IDX_INC;
			end
			ST_CRC_CMP: begin
				cmd.rd     = 1'b1;
				cmd.rd_off = OFF_ZERO;
				state_d    = stat.crc_ok ? ST_F_ADDR : ST_ECHO_DROP;
			end
			ST_F_ADDR: begin
				cmd.addr_ld = 1'b1;
				cmd.rd      = 1'b1;
				cmd.rd_off  = OFF_TWO;
				state_d     = ST_F_TYPE;
			end
			ST_F_TYPE: begin
				cmd.type_ld = 1'b1;
				state_d     = ST_F_DEC;
			end
			ST_F_DEC: begin
				cmd.ch_clr = 1'b1;
				priority if (!stat.chan_hit) state_d = ST_F_OTHER;
				else if (!stat.link)         state_d = ST_F_UP;
				else                         state_d = ST_CH_W0;
			end
			ST_F_OTHER: if (stat.out_free) begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_OTHER;
				state_d  = ST_F_DROP;
			end
			ST_F_UP: if (stat.out_free) begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_UP;
				state_d  = ST_CH_W0;
			end
			ST_CH_W0: begin
				cmd.idx_op  = IDX_CHAN;
				cmd.win_clr = 1'b1;
				state_d     = ST_CH_R0;
			end
			ST_CH_R0: begin
				cmd.rd     = 1'b1;
				cmd.rd_off = OFF_IDX;
				cmd.idx_op = IDX_INC;
				state_d    = ST_CH_R1;
			end
			ST_CH_R1: begin
				cmd.win_shift = 1'b1;
				cmd.rd        = 1'b1;
				cmd.rd_off    = OFF_IDX;
				cmd.idx_op    = IDX_INC;
				state_d       = ST_CH_R2;
			end
			ST_CH_R2: begin
				cmd.win_shift = 1'b1;
				cmd.rd        = 1'b1;
				cmd.rd_off    = OFF_IDX;
				state_d       = ST_CH_R3;
			end
			ST_CH_R3: begin
				cmd.win_shift = 1'b1;
				state_d       = ST_CH_MUL;
			end
			ST_CH_MUL: begin
				cmd.mul_ld = 1'b1;
				state_d    = ST_CH_DIV;
			end
			ST_CH_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_CH_WAIT;
			end
			ST_CH_WAIT: if (!stat.div_busy) state_d = ST_CH_EMIT;
			ST_CH_EMIT: if (stat.out_free) begin
				cmd.emit    = 1'b1;
				cmd.kind    = KIND_CHAN;
				cmd.val_sel = VAL_SCALE;
				if (stat.last_chan) begin
					state_d = ST_CH_DONE;
				end else begin
					cmd.ch_inc = 1'b1;
					state_d    = ST_CH_W0;
				end
			end
			ST_CH_DONE: begin
				cmd.link_set = 1'b1;
				state_d      = ST_F_DROP;
			end
			ST_F_DROP: begin
				cmd.drop_op = DROP_FRAME;
				state_d     = ST_SCAN;
			end
			ST_FULLCHK: begin
				cmd.drop_op = DROP_FULL;
				state_d     = ST_FINISH;
			end
			ST_FINISH: if (stat.out_free) begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_T_CHK: begin
				if (stat.flush) begin
					cmd.idx_op = IDX_ZERO;
					state_d    = ST_T_FL;
				end else begin
					state_d = ST_T_DOWN;
				end
			end
			ST_T_FL: begin
				if (stat.flush_more) begin
					cmd.rd     = 1'b1;
					cmd.rd_off = OFF_IDX;
					state_d    = ST_T_FE;
				end else begin
					cmd.drop_op = DROP_ALL;
					state_d     = ST_T_DOWN;
				end
			end
			ST_T_FE: if (stat.out_free) begin
				cmd.emit    = 1'b1;
				cmd.kind    = KIND_ECHO;
				cmd.val_sel = VAL_RDATA;
				cmd.idx_op  = IDX_INC;
				state_d     = ST_T_FL;
			end
			ST_T_DOWN: begin
				if (!stat.down) begin
					state_d = ST_FINISH;
				end else if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = KIND_DOWN;
					cmd.link_clr = 1'b1;
					state_d      = ST_FINISH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign in_ready = state_q == ST_IDLE;
endmodule
`default_nettype wire

// ===== hdl/rc_link_frame_receiver.sv =====
`default_nettype none
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_data   (cmd, rx_byte)
// out      out_valid / out_ready out_data  (kind, value, frame_type, channel_index, last)
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One request at a time. A byte is echoed in passthrough, else appended and the
// buffer scanned: length check, CRC check, and for an accepted RC frame a read,
// multiply and divide per channel; a tick may flush bytes and report link-down.
// The 64-byte buffer is a circular memory; its one read port sets the pace.
// Reset clears the counters, link state and handshakes; buffer contents stay
// undefined until written. Output stalls hold the controller in place; the
// output register lets a finished request drain while the next one is taken.
module rc_link_frame_receiver (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire rclfr_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rclfr_pkg::out_item_t      out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [15:0]          cfg_data
);
	import rclfr_pkg::*;

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// configuration registers; always ready, a write lands at once, so keep
	// writes to times when no request is in flight
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fc_address        <= 8'd200;
			cfg_q.raw_low           <= 11'd172;
			cfg_q.raw_high          <= 11'd1811;
			cfg_q.packet_timeout_ms <= 16'd100;
			cfg_q.failsafe_ms       <= 16'd300;
			cfg_q.passthrough       <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FC_ADDRESS:  cfg_q.fc_address        <= cfg_data[7:0];
				REG_RAW_LOW:     cfg_q.raw_low           <= cfg_data[10:0];
				REG_RAW_HIGH:    cfg_q.raw_high          <= cfg_data[10:0];
				REG_PKT_TIMEOUT: cfg_q.packet_timeout_ms <= cfg_data;
				REG_FAILSAFE:    cfg_q.failsafe_ms       <= cfg_data;
				REG_PASSTHROUGH: cfg_q.passthrough       <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// sequence the scan, CRC, unpack and flush
	rclfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// buffer, counters, CRC, scaling and result staging
	rclfr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg_q),
		.in_item   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_data)
	);
endmodule
`default_nettype wire
